### hdl/bat_pkg.sv
// Shared types and constants for the breakpoint address table.
// No dependencies; used by bat_cell and breakpoint_address_table.
package bat_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int ADDR_W          = 16;
  localparam int COUNT_OUT_W     = 6;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_LOOKUP = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2
  } status_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic valid;  // cell index is below the entry count
    logic cmp;    // capture compare result
    logic load;   // write the request address
    logic shift;  // take the upper neighbor's entry
  } cell_ctl_t;

endpackage

### hdl/bat_cell.sv
// One table entry: holds an address, compares it against the request and
// shifts in its upper neighbor's entry on remove. Depends on bat_pkg.
module bat_cell (
  input  logic                      clk,
  input  logic [bat_pkg::ADDR_W-1:0] addr,
  input  bat_pkg::cell_ctl_t        ctl,
  input  logic [bat_pkg::ADDR_W-1:0] next_entry,
  output logic [bat_pkg::ADDR_W-1:0] entry,
  output logic                      match
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= addr;
    end else if (ctl.shift) begin
      entry <= next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      match <= ctl.valid && (entry == addr);
    end
  end

endmodule

### hdl/breakpoint_address_table.sv
// Breakpoint address table: a compacted list of up to TABLE_DEPTH addresses
// with insert, remove-first-match, clear-all and lookup requests. Each request
// goes through these steps from acceptance to its result word: latch the
// request, compare every cell's entry with the address, pick the lowest
// matching cell, then shift or load the cells and register the result, which
// waits while an earlier result is not yet taken. A new request is taken once
// the previous one has reached the output register, even while that result
// still waits. Depends on bat_pkg and bat_cell.
module breakpoint_address_table #(
  parameter int TABLE_DEPTH = bat_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      req_type,
  input  logic [bat_pkg::ADDR_W-1:0]      address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic [1:0]                      status,
  output logic [bat_pkg::COUNT_OUT_W-1:0] entry_count
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MATCH = 4'b0010,
    S_SEL   = 4'b0100,
    S_APPLY = 4'b1000
  } state_t;

  state_t                       state;
  bat_pkg::req_t                op;
  logic [bat_pkg::ADDR_W-1:0]   addr;
  logic [CW-1:0]                count;
  logic [TABLE_DEPTH-1:0]       match_vec;
  logic [TABLE_DEPTH-1:0]       lowest;
  logic                         any;
  logic [TABLE_DEPTH-1:0]       at_or_above;
  logic [TABLE_DEPTH-1:0]       load_vec;
  logic [TABLE_DEPTH-1:0]       shift_vec;
  logic [bat_pkg::ADDR_W-1:0]   entries [TABLE_DEPTH];
  logic                         apply_go;
  logic                         full;

  assign in_ready    = (state == S_IDLE);
  assign apply_go    = (state == S_APPLY) && (!out_valid || out_ready);
  assign full        = (count >= CW'(TABLE_DEPTH));
  assign at_or_above = ~(lowest - TABLE_DEPTH'(1));

  always_comb begin
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      load_vec[j]  = apply_go && (op == bat_pkg::REQ_INSERT) && (count == CW'(j));
      shift_vec[j] = apply_go && (op == bat_pkg::REQ_REMOVE) && any && at_or_above[j];
    end
  end

  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    bat_pkg::cell_ctl_t         ctl;
    logic [bat_pkg::ADDR_W-1:0] next_entry;

    assign ctl.valid = (CW'(j) < count);
    assign ctl.cmp   = (state == S_MATCH);
    assign ctl.load  = load_vec[j];
    assign ctl.shift = shift_vec[j];

    if (j == TABLE_DEPTH - 1) begin : g_top
      assign next_entry = entries[j];
    end else begin : g_mid
      assign next_entry = entries[j + 1];
    end

    bat_cell u_cell (
      .clk        (clk),
      .addr       (addr),
      .ctl        (ctl),
      .next_entry (next_entry),
      .entry      (entries[j]),
      .match      (match_vec[j])
    );
  end

  // Request latch and lowest-match select.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op   <= bat_pkg::req_t'(req_type);
      addr <= address;
    end
    if (state == S_SEL) begin
      lowest <= match_vec & (~match_vec + TABLE_DEPTH'(1));
      any    <= |match_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (apply_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MATCH;
          end
        end
        S_MATCH: state <= S_SEL;
        S_SEL:   state <= S_APPLY;
        S_APPLY: begin
          if (apply_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (apply_go) begin
        case (op)
          bat_pkg::REQ_INSERT: begin
            if (!full) begin
              count <= count + CW'(1);
            end
          end
          bat_pkg::REQ_REMOVE: begin
            if (any) begin
              count <= count - CW'(1);
            end
          end
          bat_pkg::REQ_CLEAR: count <= '0;
          default: ;
        endcase
      end
    end
  end

  // Result word; hold until taken.
  always_ff @(posedge clk) begin
    if (apply_go) begin
      hit <= (op == bat_pkg::REQ_LOOKUP) && any;
      case (op)
        bat_pkg::REQ_INSERT: begin
          if (full) begin
            status      <= bat_pkg::ST_FULL;
            entry_count <= bat_pkg::COUNT_OUT_W'(count);
          end else begin
            status      <= bat_pkg::ST_DONE;
            entry_count <= bat_pkg::COUNT_OUT_W'(count + CW'(1));
          end
        end
        bat_pkg::REQ_REMOVE: begin
          if (any) begin
            status      <= bat_pkg::ST_DONE;
            entry_count <= bat_pkg::COUNT_OUT_W'(count - CW'(1));
          end else begin
            status      <= bat_pkg::ST_NOMATCH;
            entry_count <= bat_pkg::COUNT_OUT_W'(count);
          end
        end
        bat_pkg::REQ_CLEAR: begin
          status      <= bat_pkg::ST_DONE;
          entry_count <= '0;
        end
        default: begin
          status      <= bat_pkg::ST_DONE;
          entry_count <= bat_pkg::COUNT_OUT_W'(count);
        end
      endcase
    end
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for breakpoint_address_table: directed and random
// insert/remove/clear/lookup words checked against an in-bench table model.
// Depends on bat_pkg and the breakpoint_address_table RTL.
module testbench;

  localparam int DEPTH       = bat_pkg::TABLE_DEPTH_DEF;
  localparam int AW          = bat_pkg::ADDR_W;
  localparam int CNT_W       = bat_pkg::COUNT_OUT_W;
  localparam int RANDOM_REQS = 1100;
  localparam int STALL_LIMIT = 2000;
  localparam int GAP_PCT     = 32;
  localparam int CALM_FIRST  = 400;
  localparam int CALM_LAST   = 650;
  localparam int POOL_SIZE   = 6;

  typedef struct packed {
    bat_pkg::req_t kind;
    logic [AW-1:0] addr;
  } bp_request_t;

  typedef struct packed {
    logic             hit;
    bat_pkg::status_t status;
    logic [CNT_W-1:0] count;
  } bp_result_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_BALANCED} phase_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       req_type = bat_pkg::REQ_LOOKUP;
  logic [AW-1:0]    address = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             hit;
  logic [1:0]       status;
  logic [CNT_W-1:0] entry_count;

  bp_request_t   pending_requests[$];
  bp_result_t    expected_results[$];
  bp_request_t   next_req;
  bp_result_t    want;
  logic [AW-1:0] bp_entries[DEPTH];
  int            bp_count = 0;
  logic [AW-1:0] addr_pool[POOL_SIZE];
  int            sent_count = 0;
  int            recv_count = 0;
  int            err_count = 0;
  int            stall_cycles = 0;

  breakpoint_address_table u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .address     (address),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .status      (status),
    .entry_count (entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted request to the table copy and return its result word.
  function automatic bp_result_t apply_request(bp_request_t rq);
    bp_result_t r;
    int         first;
    r.hit    = 1'b0;
    r.status = bat_pkg::ST_DONE;
    first    = -1;
    for (int i = 0; i < bp_count; i++)
      if (first < 0 && bp_entries[i] == rq.addr) first = i;
    case (rq.kind)
      bat_pkg::REQ_INSERT: begin
        if (bp_count >= DEPTH) begin
          r.status = bat_pkg::ST_FULL;
        end else begin
          bp_entries[bp_count] = rq.addr;
          bp_count++;
        end
      end
      bat_pkg::REQ_REMOVE: begin
        if (first < 0) begin
          r.status = bat_pkg::ST_NOMATCH;
        end else begin
          // close the hole: later entries move down one place
          for (int j = first; j < bp_count - 1; j++) bp_entries[j] = bp_entries[j + 1];
          bp_count--;
        end
      end
      bat_pkg::REQ_CLEAR: bp_count = 0;
      default:            r.hit = (first >= 0);
    endcase
    r.count = CNT_W'(bp_count);
    return r;
  endfunction

  function automatic bit take_gap(int n);
    if (n >= CALM_FIRST && n < CALM_LAST) return 1'b0;
    return $urandom_range(0, 99) < GAP_PCT;
  endfunction

  function automatic void add_request(bat_pkg::req_t kind, logic [AW-1:0] addr);
    bp_request_t rq;
    rq.kind = kind;
    rq.addr = addr;
    pending_requests.push_back(rq);
  endfunction

  // Mostly reuse a few addresses so removes and lookups find matches.
  function automatic logic [AW-1:0] pick_address(int pool_pct);
    if ($urandom_range(0, 99) < pool_pct)
      return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    return AW'($urandom_range(0, 65535));
  endfunction

  function automatic void refresh_pool();
    int roll;
    for (int i = 0; i < POOL_SIZE; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10)      addr_pool[i] = '0;
      else if (roll < 20) addr_pool[i] = '1;
      else                addr_pool[i] = AW'($urandom_range(0, 65535));
    end
  endfunction

  // Driver: hold the word until accepted, then advance or idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        next_req.kind = bat_pkg::req_t'(req_type);
        next_req.addr = address;
        expected_results.push_back(apply_request(next_req));
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 && !take_gap(sent_count)) begin
          next_req = pending_requests.pop_front();
          in_valid <= 1'b1;
          req_type <= next_req.kind;
          address  <= next_req.addr;
          sent_count++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no request outstanding");
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, hit);
            err_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            err_count++;
          end
          if (entry_count !== want.count) begin
            $error("entry_count: expected %0d, actual %0d", want.count, entry_count);
            err_count++;
          end
        end
        recv_count++;
      end
      out_ready <= !take_gap(recv_count);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    phase_t phase;
    int     phase_len;
    int     roll;
    int     made;

    // empty table, duplicates, first-match removal, clear
    add_request(bat_pkg::REQ_LOOKUP, 16'h0000);
    add_request(bat_pkg::REQ_REMOVE, 16'h0000);
    add_request(bat_pkg::REQ_CLEAR,  16'h0000);
    add_request(bat_pkg::REQ_INSERT, 16'h0000);
    add_request(bat_pkg::REQ_INSERT, 16'hFFFF);
    add_request(bat_pkg::REQ_INSERT, 16'h0000);
    add_request(bat_pkg::REQ_INSERT, 16'h8001);
    add_request(bat_pkg::REQ_LOOKUP, 16'hFFFF);
    add_request(bat_pkg::REQ_LOOKUP, 16'h7FFE);
    add_request(bat_pkg::REQ_REMOVE, 16'h0000);
    add_request(bat_pkg::REQ_LOOKUP, 16'h0000);
    add_request(bat_pkg::REQ_REMOVE, 16'h0000);
    add_request(bat_pkg::REQ_LOOKUP, 16'h0000);
    add_request(bat_pkg::REQ_REMOVE, 16'h1234);
    add_request(bat_pkg::REQ_REMOVE, 16'h8001);
    add_request(bat_pkg::REQ_REMOVE, 16'hFFFF);
    add_request(bat_pkg::REQ_INSERT, 16'hAAAA);
    add_request(bat_pkg::REQ_INSERT, 16'h5555);
    add_request(bat_pkg::REQ_CLEAR,  16'hFFFF);
    // old entries must not answer after a clear
    add_request(bat_pkg::REQ_LOOKUP, 16'hAAAA);
    add_request(bat_pkg::REQ_REMOVE, 16'h5555);

    // start random traffic by overfilling the table
    refresh_pool();
    for (int i = 0; i < DEPTH + 4; i++) add_request(bat_pkg::REQ_INSERT, pick_address(50));
    made = DEPTH + 4;

    phase = PH_DRAIN;
    while (made < RANDOM_REQS) begin
      phase_len = $urandom_range(20, 80);
      if ($urandom_range(0, 3) == 0) refresh_pool();
      for (int i = 0; i < phase_len && made < RANDOM_REQS; i++) begin
        roll = $urandom_range(0, 99);
        case (phase)
          PH_FILL: begin
            if (roll < 75)      add_request(bat_pkg::REQ_INSERT, pick_address(85));
            else if (roll < 85) add_request(bat_pkg::REQ_REMOVE, pick_address(80));
            else                add_request(bat_pkg::REQ_LOOKUP, pick_address(70));
          end
          PH_DRAIN: begin
            if (roll < 15)      add_request(bat_pkg::REQ_INSERT, pick_address(85));
            else if (roll < 70) add_request(bat_pkg::REQ_REMOVE, pick_address(80));
            else                add_request(bat_pkg::REQ_LOOKUP, pick_address(70));
          end
          default: begin
            if (roll < 35)      add_request(bat_pkg::REQ_INSERT, pick_address(85));
            else if (roll < 65) add_request(bat_pkg::REQ_REMOVE, pick_address(80));
            else if (roll < 67) add_request(bat_pkg::REQ_CLEAR, pick_address(0));
            else                add_request(bat_pkg::REQ_LOOKUP, pick_address(70));
          end
        endcase
        made++;
      end
      phase = phase_t'($urandom_range(0, 2));
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_requests.size() > 0 || in_valid || expected_results.size() > 0);
    // let any stray word surface
    repeat (12) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
